FILE: src/hca_pkg.sv
// ----------------------------------------------------------------------------
// hca_pkg
// Shared constants, types and helpers of the HOG cell histogram averager.
// ----------------------------------------------------------------------------
package hca_pkg;

    // window geometry
    localparam int CELLS_ACROSS    = 4;
    localparam int CELLS_DOWN      = 4;
    localparam int BINS            = 9;
    localparam int CELLS_PER_BLOCK = 4;

    localparam int NUM_CELLS = CELLS_ACROSS * CELLS_DOWN;
    localparam int NUM_SUMS  = NUM_CELLS * BINS;
    localparam int BLOCKS_X  = CELLS_ACROSS - 1;
    localparam int BLOCKS_Y  = CELLS_DOWN - 1;

    // field widths
    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 16;
    localparam int INDEX_W  = 8;
    localparam int SUM_W    = 18;
    localparam int COUNT_W  = 3;

    // internal widths
    localparam int IDX_W  = $clog2(NUM_SUMS);
    localparam int CELL_W = $clog2(NUM_CELLS);
    localparam int BIN_W  = $clog2(BINS);
    localparam int BX_W   = (BLOCKS_X > 1) ? $clog2(BLOCKS_X) : 1;
    localparam int BY_W   = (BLOCKS_Y > 1) ? $clog2(BLOCKS_Y) : 1;
    localparam int CNR_W  = $clog2(CELLS_PER_BLOCK);

    // command queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // index / BINS as a multiply by a rounded-up reciprocal, exact for 8-bit indexes
    localparam int             RECIP_SHIFT = 16;
    localparam logic [15:0]    CELL_RECIP  = 16'(((2 ** RECIP_SHIFT) + BINS - 1) / BINS);

    // sum / 3: (2^17 + 1) / 3, overshoots by at most one
    localparam int             DIV3_SHIFT = 17;
    localparam int             DIV3_W     = 17;
    localparam logic [16:0]    DIV3_MUL   = 17'd43691;

    localparam logic [VALUE_W-1:0] AVG_MAX = '1;

    typedef enum logic [OPCODE_W-1:0] {
        OPC_START = 2'd0,
        OPC_PUSH  = 2'd1,
        OPC_READ  = 2'd2,
        OPC_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_PUSH,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [IDX_W-1:0]   sum_idx;
        logic [CELL_W-1:0]  cell_no;
        logic               last_bin;
        logic               in_range;
        logic [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_back_state;

    function automatic logic [CELL_W-1:0] index_to_cell(input logic [INDEX_W-1:0] idx);
        logic [INDEX_W+15:0] prod;
        prod = {16'b0, idx} * {{INDEX_W{1'b0}}, CELL_RECIP};
        return prod[RECIP_SHIFT +: CELL_W];
    endfunction

endpackage

FILE: src/hca_front.sv
// ----------------------------------------------------------------------------
// hca_front
// Classifies accepted transactions and tracks the load position of the window.
// ----------------------------------------------------------------------------
module hca_front
    import hca_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [VALUE_W-1:0]  i_descriptor_value,
    input  logic [INDEX_W-1:0]  i_read_index,
    output logic                o_enq,
    output t_cmd                o_cmd
);

    logic [BIN_W-1:0]  r_bin,      n_bin;
    logic [CNR_W-1:0]  r_cnr,      n_cnr;
    logic [BY_W-1:0]   r_by,       n_by;
    logic [BX_W-1:0]   r_bx,       n_bx;
    logic [CELL_W-1:0] r_blk_cell, n_blk_cell;
    logic              r_full,     n_full;

    logic [CELL_W-1:0] push_cell;
    logic [IDX_W-1:0]  push_idx;
    logic              last_bin;
    logic              rd_in_range;

    always_comb begin
        // lower-left cell of the block, then the cell's offset inside it
        push_cell = r_blk_cell + CELL_W'(r_cnr[1])
                  + (r_cnr[0] ? CELL_W'(CELLS_ACROSS) : CELL_W'(0));
        push_idx  = IDX_W'(push_cell * BINS) + IDX_W'(r_bin);
        last_bin  = (r_bin == BIN_W'(BINS - 1));
        rd_in_range = (32'(i_read_index) < 32'(NUM_SUMS));
    end

    always_comb begin
        n_bin      = r_bin;
        n_cnr      = r_cnr;
        n_by       = r_by;
        n_bx       = r_bx;
        n_blk_cell = r_blk_cell;
        n_full     = r_full;
        o_enq      = 1'b0;
        o_cmd      = '0;
        o_cmd.value = i_descriptor_value;
        if (i_accept) begin
            case (t_opcode'(i_opcode))
                OPC_START: begin
                    o_enq      = 1'b1;
                    o_cmd.kind = CMD_CLEAR;
                    n_bin      = '0;
                    n_cnr      = '0;
                    n_by       = '0;
                    n_bx       = '0;
                    n_blk_cell = '0;
                    n_full     = 1'b0;
                end
                OPC_PUSH: begin
                    if (!r_full) begin
                        o_enq          = 1'b1;
                        o_cmd.kind     = CMD_PUSH;
                        o_cmd.sum_idx  = push_idx;
                        o_cmd.cell_no  = push_cell;
                        o_cmd.last_bin = last_bin;
                        o_cmd.in_range = 1'b1;
                        n_bin = r_bin + BIN_W'(1);
                        if (last_bin) begin
                            n_bin = '0;
                            n_cnr = r_cnr + CNR_W'(1);
                            if (r_cnr == CNR_W'(CELLS_PER_BLOCK - 1)) begin
                                n_by       = r_by + BY_W'(1);
                                n_blk_cell = r_blk_cell + CELL_W'(CELLS_ACROSS);
                                if (r_by == BY_W'(BLOCKS_Y - 1)) begin
                                    // next block column starts at its bottom cell
                                    n_by       = '0;
                                    n_bx       = r_bx + BX_W'(1);
                                    n_blk_cell = CELL_W'(r_bx) + CELL_W'(1);
                                    if (r_bx == BX_W'(BLOCKS_X - 1)) begin
                                        n_full = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                OPC_READ: begin
                    o_enq          = 1'b1;
                    o_cmd.kind     = CMD_READ;
                    o_cmd.in_range = rd_in_range;
                    o_cmd.sum_idx  = rd_in_range ? IDX_W'(i_read_index) : IDX_W'(0);
                    o_cmd.cell_no  = rd_in_range ? index_to_cell(i_read_index)
                                                 : CELL_W'(0);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin      <= '0;
            r_cnr      <= '0;
            r_by       <= '0;
            r_bx       <= '0;
            r_blk_cell <= '0;
            r_full     <= 1'b0;
        end else begin
            r_bin      <= n_bin;
            r_cnr      <= n_cnr;
            r_by       <= n_by;
            r_bx       <= n_bx;
            r_blk_cell <= n_blk_cell;
            r_full     <= n_full;
        end
    end

endmodule

FILE: src/hca_queue.sv
// ----------------------------------------------------------------------------
// hca_queue
// Small command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module hca_queue
    import hca_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    t_cmd               r_entries [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_PTR_W:0]   r_count,  n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + Q_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + Q_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(i_pop);
        o_cmd          = r_entries[r_rd_ptr];
        o_status.valid = (r_count != '0);
        o_status.full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: src/hca_back.sv
// ----------------------------------------------------------------------------
// hca_back
// Executes queued commands: bin sum memory read-modify-write, cell counts,
// window clear and averaged reads.
// ----------------------------------------------------------------------------
module hca_back
    import hca_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_result_valid,
    output logic [VALUE_W-1:0] o_average_value,
    output logic [COUNT_W-1:0] o_cell_updates
);

    t_back_state r_state, n_state;

    logic [SUM_W-1:0]   r_sums [NUM_SUMS];
    logic [NUM_SUMS-1:0] r_sum_vld;
    logic [COUNT_W-1:0] r_counts [NUM_CELLS];

    t_cmd               r_cmd;
    logic [SUM_W-1:0]   r_rd_data;
    logic               r_rd_vld;
    logic [COUNT_W-1:0] r_cnt;

    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_avg;
    logic [COUNT_W-1:0] r_upd;

    logic clr;
    logic wr_en;
    logic cnt_wr;

    logic [SUM_W-1:0]        sum_cur;
    logic [SUM_W-1:0]        sum_new;
    logic [SUM_W+DIV3_W-1:0] div3_prod;
    logic [SUM_W-1:0]        div3_q;
    logic [SUM_W+1:0]        div3_chk;
    logic [SUM_W-1:0]        quot;
    logic [VALUE_W-1:0]      avg_next;
    logic [COUNT_W-1:0]      upd_next;

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        clr         = 1'b0;
        wr_en       = 1'b0;
        cnt_wr      = 1'b0;
        n_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == CMD_CLEAR) begin
                        clr = 1'b1;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                case (r_cmd.kind)
                    CMD_PUSH: begin
                        wr_en  = 1'b1;
                        cnt_wr = r_cmd.last_bin;
                    end
                    CMD_READ: begin
                        n_out_valid = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath: accumulate and divide by the count
    always_comb begin
        sum_cur   = r_rd_vld ? r_rd_data : SUM_W'(0);
        sum_new   = sum_cur + SUM_W'(r_cmd.value);
        div3_prod = {{DIV3_W{1'b0}}, sum_cur} * {{SUM_W{1'b0}}, DIV3_MUL};
        div3_q    = div3_prod[DIV3_SHIFT +: SUM_W];
        div3_chk  = {1'b0, div3_q, 1'b0} + {2'b0, div3_q};
        // reciprocal can overshoot by one
        if (div3_chk > {2'b0, sum_cur}) begin
            div3_q = div3_q - SUM_W'(1);
        end
        case (r_cnt)
            3'd1:    quot = sum_cur;
            3'd2:    quot = sum_cur >> 1;
            3'd3:    quot = div3_q;
            3'd4:    quot = sum_cur >> 2;
            default: quot = '0;
        endcase
        if (!r_cmd.in_range) begin
            avg_next = '0;
            upd_next = '0;
        end else begin
            avg_next = (quot > SUM_W'(AVG_MAX)) ? AVG_MAX : quot[VALUE_W-1:0];
            upd_next = r_cnt;
        end
    end

    // bin sum memory
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_sums[i_cmd.sum_idx];
        end
        if (wr_en) begin
            r_sums[r_cmd.sum_idx] <= sum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd    <= i_cmd;
            r_rd_vld <= r_sum_vld[i_cmd.sum_idx];
            r_cnt    <= r_counts[i_cmd.cell_no];
        end
        if (n_out_valid) begin
            r_avg <= avg_next;
            r_upd <= upd_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_sum_vld   <= '0;
            for (int c = 0; c < NUM_CELLS; c++) begin
                r_counts[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (clr) begin
                r_sum_vld <= '0;
                for (int c = 0; c < NUM_CELLS; c++) begin
                    r_counts[c] <= '0;
                end
            end else begin
                if (wr_en) begin
                    r_sum_vld[r_cmd.sum_idx] <= 1'b1;
                end
                if (cnt_wr) begin
                    r_counts[r_cmd.cell_no] <= r_cnt + COUNT_W'(1);
                end
            end
        end
    end

    assign o_result_valid  = r_out_valid;
    assign o_average_value = r_avg;
    assign o_cell_updates  = r_upd;

endmodule

FILE: src/hog_cell_histogram_averager.sv
// ----------------------------------------------------------------------------
// hog_cell_histogram_averager
// Folds overlapping 2x2-cell HOG block descriptors into averaged cell bins.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+--------------------------------------
//  command   | i_start, o_busy           | i_opcode, i_descriptor_value,
//            |                           | i_read_index
//  result    | o_result_valid (strobe)   | o_average_value, o_cell_updates
//
//  a transaction is taken when i_start is high and o_busy low; o_busy is the
//  command queue being full (four entries)
//  the execute side does a push or read in steps (memory read at the pop, then
//  add-and-write or divide) and a start at the pop alone, so it takes no new
//  push or read until the last one has finished
//  with the queue empty, a read passes the queue entry, memory read and divide,
//  and its result is registered; synchronous active-low reset empties the queue
//  and clears sums and counts; the result strobe cannot be stalled
// ----------------------------------------------------------------------------
module hog_cell_histogram_averager
    import hca_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [VALUE_W-1:0]  i_descriptor_value,
    input  logic [INDEX_W-1:0]  i_read_index,
    output logic                o_result_valid,
    output logic [VALUE_W-1:0]  o_average_value,
    output logic [COUNT_W-1:0]  o_cell_updates
);

    logic      accept;
    logic      enq;
    t_cmd      front_cmd;
    t_cmd      q_cmd;
    t_q_status q_status;
    logic      pop;

    assign accept = i_start && !q_status.full;
    assign o_busy = q_status.full;

    hca_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_opcode           (i_opcode),
        .i_descriptor_value (i_descriptor_value),
        .i_read_index       (i_read_index),
        .o_enq              (enq),
        .o_cmd              (front_cmd)
    );

    hca_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (enq),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (q_cmd),
        .o_status (q_status)
    );

    hca_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_status.valid),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .o_result_valid  (o_result_valid),
        .o_average_value (o_average_value),
        .o_cell_updates  (o_cell_updates)
    );

endmodule

FILE: src/hca_checker.sv
// ----------------------------------------------------------------------------
// hca_checker
// Port-level checks of the HOG cell histogram averager, bound to the top.
// ----------------------------------------------------------------------------
module hca_checker
    import hca_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_result_valid,
    input logic [VALUE_W-1:0] o_average_value,
    input logic [COUNT_W-1:0] o_cell_updates
);

    // queue is not full (no busy) and no strobe right after reset
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (!o_busy && !o_result_valid))
        else $error("busy or result strobe right after reset");

    // the queue only fills through an accepted transaction
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy rose without a transaction");

    // a cell never sees more than four blocks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_cell_updates <= COUNT_W'(CELLS_PER_BLOCK)))
        else $error("cell update count out of range");

    // never updated cells average to zero
    a_zero_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_cell_updates == '0)) |-> (o_average_value == '0))
        else $error("nonzero average for a cell with no updates");

endmodule

bind hog_cell_histogram_averager hca_checker u_hca_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_result_valid  (o_result_valid),
    .o_average_value (o_average_value),
    .o_cell_updates  (o_cell_updates)
);
